>>> design/pol_pkg.sv
// ---------------------------------------------------------------------------
// pol_pkg: shared types and codes for the positional ordered list unit
// Command and status codes and controller states.
// ---------------------------------------------------------------------------
`default_nettype none
package pol_pkg;
    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_END   = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_LIST      = 3'd6,
        CMD_NONE      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_RESP
    } state_t;
endpackage
`default_nettype wire

>>> design/positional_ordered_list_unit.sv
// ---------------------------------------------------------------------------
// positional_ordered_list_unit: bounded ordered list with positional edits
// Inserts, deletes and lists signed 32-bit entries held in one memory.
// ---------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | cmd, position, item_value
// out     | out_valid/out_ready| status, out_value, entry_count, last
//
// An edit reads and writes each entry that it moves, one after another,
// through the memory's read and write ports; an insert then writes the new
// item, and either edit then updates the count and registers its result.
// Listing reads the entries in order and registers each as a result. A bad
// position, empty, full or unused command goes from idle straight to the
// response state. Reset clears the state, the count and the output valid;
// entries are written before they are read. A stalled output holds the
// controller; a new item is taken in the cycle after the last result is taken.
`default_nettype none
module positional_ordered_list_unit
    import pol_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [4:0]  position,
    input  wire logic [31:0] item_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [1:0]  status,
    output logic      [31:0] out_value,
    output logic      [4:0]  entry_count,
    output logic             last
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // current slot
    logic [CW-1:0] stop_reg, stop_next;   // last slot of the shift
    logic          ins_reg, ins_next;
    logic [31:0]   val_reg, val_next;
    logic          ov_reg, ov_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   ovalue_reg, ovalue_next;
    logic          last_reg, last_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    pol_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CW:0] pos_w, cnt_w;
    assign pos_w = (CW+1)'(position);
    assign cnt_w = {1'b0, count_reg};

    // Controller state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        stop_reg   <= stop_next;
        ins_reg    <= ins_next;
        val_reg    <= val_next;
        st_reg     <= st_next;
        ovalue_reg <= ovalue_next;
        last_reg   <= last_next;
    end

    // Next state: decode, shift loop, list loop and response.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        stop_next   = stop_reg;
        ins_next    = ins_reg;
        val_next    = val_reg;
        ov_next     = ov_reg;
        st_next     = st_reg;
        ovalue_next = ovalue_reg;
        last_next   = last_reg;
        in_ready    = 1'b0;
        we          = 1'b0;
        waddr       = idx_reg[AW-1:0];
        wdata       = rdata;
        raddr       = idx_reg[AW-1:0];

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !ov_reg;
                if (in_valid && !ov_reg)
                begin
                    st_next     = ST_OK;
                    ovalue_next = '0;
                    last_next   = 1'b1;
                    val_next    = item_value;
                    state_next  = S_RESP;
                    unique case (cmd_t'(cmd))
                        CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS:
                        begin
                            ins_next = 1'b1;
                            idx_next = count_reg;
                            if (cnt_w >= (CW+1)'(DEPTH))
                                st_next = ST_FULL;
                            else if (cmd_t'(cmd) == CMD_INS_POS &&
                                     (position == 5'd0 || pos_w > cnt_w + 1'b1))
                                st_next = ST_BADPOS;
                            else
                            begin
                                if (cmd_t'(cmd) == CMD_INS_FRONT)
                                    stop_next = '0;
                                else if (cmd_t'(cmd) == CMD_INS_END)
                                    stop_next = count_reg;
                                else
                                    stop_next = CW'(pos_w - 1'b1);
                                state_next = S_SHIFT_RD;
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS:
                        begin
                            ins_next  = 1'b0;
                            stop_next = count_reg - 1'b1;
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else if (cmd_t'(cmd) == CMD_DEL_POS &&
                                     (position == 5'd0 || pos_w > cnt_w))
                                st_next = ST_BADPOS;
                            else
                            begin
                                if (cmd_t'(cmd) == CMD_DEL_FRONT)
                                    idx_next = '0;
                                else if (cmd_t'(cmd) == CMD_DEL_END)
                                    idx_next = count_reg - 1'b1;
                                else
                                    idx_next = CW'(pos_w - 1'b1);
                                state_next = S_SHIFT_RD;
                            end
                        end
                        CMD_LIST:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                                state_next = S_LIST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT_RD:
            begin
                // Insert moves slot idx-1 up to idx; delete moves idx+1 down.
                if (ins_reg)
                begin
                    if (idx_reg == stop_reg)
                    begin
                        we         = 1'b1;
                        wdata      = val_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        raddr      = AW'(idx_reg - 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (idx_reg == stop_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        raddr      = AW'(idx_reg + 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                we         = 1'b1;
                idx_next   = ins_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_LIST_RD:
            begin
                if (!ov_reg || out_ready)
                    state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                ov_next     = 1'b1;
                st_next     = ST_OK;
                ovalue_next = rdata;
                last_next   = (idx_reg + 1'b1 == count_reg);
                idx_next    = idx_reg + 1'b1;
                state_next  = (idx_reg + 1'b1 == count_reg) ? S_IDLE : S_LIST_RD;
            end
            S_RESP:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign out_value   = ovalue_reg;
    assign entry_count = 5'(count_reg);
    assign last        = last_reg;
endmodule
`default_nettype wire

>>> design/pol_mem.sv
// ---------------------------------------------------------------------------
// pol_mem: entry storage
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module pol_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);
    logic [31:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
